[rtl/ptm_pkg.sv]
// shared types, constants and helpers for the four-level page table manager
// no dependencies
package ptm_pkg;

  localparam int TABLE_PAGES_DEF = 64;
  localparam int IDX_W  = 9;
  localparam int PAGE_W = 40;
  localparam int VA_W   = 64;
  localparam int PA_W   = 52;
  localparam int FL_W   = 3;
  localparam int ENT_W  = 64;

  localparam logic [1:0] FN_MAP       = 2'd0;
  localparam logic [1:0] FN_UNMAP     = 2'd1;
  localparam logic [1:0] FN_PROTECT   = 2'd2;
  localparam logic [1:0] FN_TRANSLATE = 2'd3;

  localparam int E_P    = 0;
  localparam int E_WR   = 1;
  localparam int E_US   = 2;
  localparam int E_HUGE = 7;
  localparam int E_NX   = 63;

  localparam int FL_WRITE = 0;
  localparam int FL_USER  = 1;
  localparam int FL_EXEC  = 2;

  typedef struct packed {
    logic              ok;
    logic [PA_W-1:0]   addr;
    logic [FL_W-1:0]   flags;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } walk_status_t;

  function automatic logic [ENT_W-1:0] make_entry(input logic [PAGE_W-1:0] page,
                                                  input logic [FL_W-1:0] fl);
    logic [ENT_W-1:0] e;
    e = '0;
    e[51:12] = page;
    e[E_P]   = 1'b1;
    e[E_WR]  = fl[FL_WRITE];
    e[E_US]  = fl[FL_USER];
    e[E_NX]  = ~fl[FL_EXEC];
    return e;
  endfunction

endpackage

[rtl/ptm_store.sv]
// table store: one write port, one read port, registered read data
// depends on ptm_pkg
module ptm_store
  import ptm_pkg::*;
#(
  parameter int DEPTH = TABLE_PAGES_DEF * 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/ptm_walker.sv]
// walk sequencer: request checks, level reads, table allocation, leaf update
// depends on ptm_pkg; drives the ports of ptm_store
module ptm_walker
  import ptm_pkg::*;
#(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF,
  parameter int DEPTH       = TABLE_PAGES * 512,
  parameter int AW          = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] base_page,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_func,
  input  logic [VA_W-1:0]   req_va,
  input  logic [PA_W-1:0]   req_pa,
  input  logic [FL_W-1:0]   req_flags,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [ENT_W-1:0]  mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [ENT_W-1:0]  mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output walk_status_t      status
);

  localparam int TW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NW = $clog2(TABLE_PAGES + 1);

  localparam logic [2:0] S_WIPE = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_ZERO = 3'd4;
  localparam logic [2:0] S_LINK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        func_r, func_nxt;
  logic [47:0]       va_r, va_nxt;
  logic [PAGE_W-1:0] pa_r, pa_nxt;
  logic [FL_W-1:0]   flags_r, flags_nxt;
  logic              user_r, user_nxt;
  logic [1:0]        lvl_r, lvl_nxt;
  logic [TW-1:0]     tbl_r, tbl_nxt;
  logic [TW-1:0]     child_r, child_nxt;
  logic [NW-1:0]     nft_r, nft_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [ENT_W-1:0]  link_r, link_nxt;
  res_t              res_r, res_nxt;

  logic [IDX_W-1:0]  idx_sel;
  logic [AW-1:0]     cur_pos;
  logic [PAGE_W-1:0] diff;
  logic [PAGE_W-1:0] child_page;
  logic              pre_ok;
  logic              canon;
  logic [ENT_W-1:0]  e;

  always_comb begin
    case (lvl_r)
      2'd0:    idx_sel = va_r[47:39];
      2'd1:    idx_sel = va_r[38:30];
      2'd2:    idx_sel = va_r[29:21];
      default: idx_sel = va_r[20:12];
    endcase
  end

  assign cur_pos    = AW'({tbl_r, idx_sel});
  assign e          = mem_rdata;
  assign diff       = e[51:12] - base_page;
  assign child_page = base_page + PAGE_W'(nft_r);
  assign canon      = (req_va[63:48] == 16'h0000) || (req_va[63:48] == 16'hffff);

  always_comb begin
    case (req_func)
      FN_MAP:     pre_ok = (req_va[11:0] == 12'h0) && (req_pa[11:0] == 12'h0) && canon;
      FN_UNMAP:   pre_ok = (req_va[11:0] == 12'h0);
      FN_PROTECT: pre_ok = (req_va[11:0] == 12'h0);
      default:    pre_ok = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    va_nxt    = va_r;
    pa_nxt    = pa_r;
    flags_nxt = flags_r;
    user_nxt  = user_r;
    lvl_nxt   = lvl_r;
    tbl_nxt   = tbl_r;
    child_nxt = child_r;
    nft_nxt   = nft_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    link_nxt  = link_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = cur_pos;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cur_pos;
    case (state_r)
      S_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          func_nxt  = req_func;
          va_nxt    = req_va[47:0];
          pa_nxt    = req_pa[51:12];
          flags_nxt = req_flags;
          user_nxt  = req_flags[FL_USER] && ((req_func == FN_MAP) || (req_func == FN_PROTECT));
          lvl_nxt   = 2'd0;
          tbl_nxt   = '0;
          res_nxt   = '0;
          state_nxt = pre_ok ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (lvl_r != 2'd3) begin
          if (!e[E_P]) begin
            if ((func_r == FN_MAP) && (nft_r < NW'(TABLE_PAGES))) begin
              child_nxt = TW'(nft_r);
              nft_nxt   = nft_r + 1'b1;
              pos_nxt   = cur_pos;
              cnt_nxt   = '0;
              link_nxt  = '0;
              link_nxt[51:12] = child_page;
              link_nxt[E_P]   = 1'b1;
              link_nxt[E_WR]  = 1'b1;
              link_nxt[E_US]  = user_r;
              state_nxt = S_ZERO;
            end
          end else if (!e[E_HUGE]) begin
            if (user_r) begin
              mem_we         = 1'b1;
              mem_wdata      = e;
              mem_wdata[E_US] = 1'b1;
            end
            if (diff < PAGE_W'(TABLE_PAGES)) begin
              tbl_nxt   = TW'(diff);
              lvl_nxt   = lvl_r + 1'b1;
              state_nxt = S_READ;
            end
          end
        end else begin
          case (func_r)
            FN_MAP: begin
              if (!e[E_P]) begin
                mem_we     = 1'b1;
                mem_wdata  = make_entry(pa_r, flags_r);
                res_nxt.ok = 1'b1;
              end
            end
            FN_UNMAP: begin
              if (e[E_P]) begin
                mem_we       = 1'b1;
                res_nxt.ok   = 1'b1;
                res_nxt.addr = {e[51:12], 12'h000};
              end
            end
            FN_PROTECT: begin
              if (e[E_P]) begin
                mem_we     = 1'b1;
                mem_wdata  = make_entry(e[51:12], flags_r);
                res_nxt.ok = 1'b1;
              end
            end
            default: begin
              if (e[E_P]) begin
                res_nxt.ok    = 1'b1;
                res_nxt.addr  = {e[51:12], va_r[11:0]};
                res_nxt.flags = {~e[E_NX], e[E_US], e[E_WR]};
              end
            end
          endcase
        end
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = AW'({child_r, cnt_r[IDX_W-1:0]});
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[IDX_W-1:0] == {IDX_W{1'b1}}) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = link_r;
        tbl_nxt   = child_r;
        lvl_nxt   = lvl_r + 1'b1;
        state_nxt = S_READ;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      nft_r   <= NW'(1);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      nft_r   <= nft_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    va_r    <= va_nxt;
    pa_r    <= pa_nxt;
    flags_r <= flags_nxt;
    user_r  <= user_nxt;
    lvl_r   <= lvl_nxt;
    tbl_r   <= tbl_nxt;
    child_r <= child_nxt;
    pos_r   <= pos_nxt;
    link_r  <= link_nxt;
    res_r   <= res_nxt;
  end

  assign req_ready       = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res             = res_r;
  assign status.clearing = (state_r == S_WIPE);
  assign status.busy     = (state_r != S_IDLE);

endmodule

[rtl/four_level_page_table_manager.sv]
// Four-level page table manager. One request at a time: the request is taken
// and checked, each table level is read and then evaluated and written back
// on the store, and the result is handed to the output register; each table
// that map allocates is zeroed before it is linked in. After reset the store
// is swept to zero, during which no request is taken.
// Depends on ptm_pkg, ptm_walker and ptm_store.
module four_level_page_table_manager
  import ptm_pkg::*;
#(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [39:0]  cfg_data,   // table_base_page
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // func, virt_addr, phys_addr, access_flags, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata   // ok, result_addr, result_flags
);

  localparam int DEPTH = TABLE_PAGES * 512;
  localparam int AW    = $clog2(DEPTH);

  logic [PAGE_W-1:0] base_r;
  logic              out_valid_r;
  res_t              out_r;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  walk_status_t      status;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  ptm_walker #(
    .TABLE_PAGES(TABLE_PAGES),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_page (base_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_func  (in_tdata[1:0]),
    .req_va    (in_tdata[65:2]),
    .req_pa    (in_tdata[117:66]),
    .req_flags (in_tdata[120:118]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .status    (status)
  );

  ptm_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.flags, out_r.addr, out_r.ok};

`ifndef ASSERT_OFF
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> !in_tready)
    else $error("request taken during store clearing");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (status.busy && !in_tready))
    else $error("second request taken while walk in progress");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_tvalid)
    else $error("result handed off but output not valid");
`endif

endmodule
